@@ rtl/core/bdls_pkg.sv @@
// Package for the dashed line stepper: operation codes, register map and
// dash configuration type. No dependencies.
package bdls_pkg;

    // Item operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Configuration register indexes (byte address = 4 * index)
    localparam int unsigned REG_ADDR_BITS = 4;
    localparam int unsigned REG_IDX_BITS  = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_DASH_ENABLE = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_DASH_PERIOD = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DASH_ON     = 2'd2;

    // Dash pattern
    localparam int unsigned DASH_BITS = 4;
    localparam logic [DASH_BITS-1:0] DASH_PERIOD_RST = 4'd10;
    localparam logic [DASH_BITS-1:0] DASH_ON_RST     = 4'd5;

    typedef struct packed {
        logic                 enable;
        logic [DASH_BITS-1:0] period;
        logic [DASH_BITS-1:0] on_len;
    } dash_cfg_t;

endpackage

@@ rtl/core/bdls_dash.sv @@
// Dash pattern evaluation: visibility of the emitted pixel and the wrapped
// next value of the dash pixel counter. Depends on bdls_pkg.
module bdls_dash
    import bdls_pkg::*;
(
    input  dash_cfg_t            cfg,
    input  logic [DASH_BITS-1:0] count,
    output logic                 visible,
    output logic [DASH_BITS-1:0] count_next
);

    logic [DASH_BITS:0] count_inc;

    // Visible while dashing is off or counter is inside the on length
    assign visible = !cfg.enable || (count < cfg.on_len);

    // Counter wraps once it would reach the period; period zero keeps it at zero
    assign count_inc  = {1'b0, count} + {{DASH_BITS{1'b0}}, 1'b1};
    assign count_next = (count_inc >= {1'b0, cfg.period}) ? '0 : count_inc[DASH_BITS-1:0];

endmodule

@@ rtl/core/bresenham_dashed_line_stepper_unit.sv @@
// Top level of the all-octant dashed Bresenham line stepper: input word
// register, single-pass step logic, result register and APB config port.
// Depends on bdls_pkg and bdls_dash.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | op, start_x, start_y, end_x, end_y
//  output   | out_valid / out_stall  | pixel_x, pixel_y, pixel_visible,
//           |                        | last_pixel, no_line
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// From acceptance to result each word passes the input register, then the
// step logic into the result register. A new word is accepted every cycle
// while the result is not stalled; the loop through the line state
// (current point, error term, dash counter) sets that rate.
// Reset clears the line state (no active line) and loads the register defaults.
// A stalled result holds; one more word waits in the input register before
// in_stall rises.
module bresenham_dashed_line_stepper_unit
    import bdls_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          pixel_visible,
    output logic                          last_pixel,
    output logic                          no_line,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [REG_ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned EB = COORD_BITS + 2;  // error term
    localparam int unsigned WB = COORD_BITS + 3;  // doubled error compare

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    dash_cfg_t                 dash_cfg_reg;
    logic                      cfg_wr;
    logic [REG_IDX_BITS-1:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[REG_ADDR_BITS-1:REG_ADDR_BITS-REG_IDX_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_cfg_reg.enable <= 1'b0;
            dash_cfg_reg.period <= DASH_PERIOD_RST;
            dash_cfg_reg.on_len <= DASH_ON_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DASH_ENABLE: dash_cfg_reg.enable <= pwdata[0];
                REG_DASH_PERIOD: dash_cfg_reg.period <= pwdata[DASH_BITS-1:0];
                REG_DASH_ON:     dash_cfg_reg.on_len <= pwdata[DASH_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_DASH_ENABLE: prdata = {31'd0, dash_cfg_reg.enable};
            REG_DASH_PERIOD: prdata = {{(32-DASH_BITS){1'b0}}, dash_cfg_reg.period};
            REG_DASH_ON:     prdata = {{(32-DASH_BITS){1'b0}}, dash_cfg_reg.on_len};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input word register
    // ------------------------------------------------------------------
    logic                   in_vld_reg;
    op_t                    op_reg;
    logic signed [CB-1:0]   sx_reg;
    logic signed [CB-1:0]   sy_reg;
    logic signed [CB-1:0]   ex_reg;
    logic signed [CB-1:0]   ey_reg;
    logic                   out_vld_reg;
    logic                   advance;
    logic                   in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= op_t'(op);
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
    end

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic signed [CB-1:0]   cur_x_reg, cur_x_next;
    logic signed [CB-1:0]   cur_y_reg, cur_y_next;
    logic signed [CB-1:0]   target_x_reg, target_x_next;
    logic signed [CB-1:0]   target_y_reg, target_y_next;
    logic [CB-1:0]          delta_x_reg, delta_x_next;
    logic [CB-1:0]          delta_y_reg, delta_y_next;
    logic signed [EB-1:0]   error_reg, error_next;
    logic                   dir_x_neg_reg, dir_x_neg_next;
    logic                   dir_y_neg_reg, dir_y_neg_next;
    logic [DASH_BITS-1:0]   dash_count_reg, dash_count_next;
    logic                   line_active_reg, line_active_next;

    // start setup: signed differences, magnitudes, directions
    logic signed [CB:0]     diff_x, diff_y;
    logic [CB:0]            abs_x, abs_y;
    logic                   start_last;

    assign diff_x = {ex_reg[CB-1], ex_reg} - {sx_reg[CB-1], sx_reg};
    assign diff_y = {ey_reg[CB-1], ey_reg} - {sy_reg[CB-1], sy_reg};
    assign abs_x  = diff_x[CB] ? (-diff_x) : diff_x;
    assign abs_y  = diff_y[CB] ? (-diff_y) : diff_y;
    assign start_last = (sx_reg == ex_reg) && (sy_reg == ey_reg);

    // step: doubled error against the deltas
    logic signed [WB-1:0]   err2, sum_x, diff_y_cmp;
    logic                   move_x, move_y;
    logic signed [CB-1:0]   step_x, step_y;
    logic signed [EB-1:0]   err_sub, err_add;
    logic signed [CB-1:0]   nx, ny;
    logic                   step_last;

    assign err2       = {error_reg, 1'b0};
    assign sum_x      = err2 + $signed({3'b000, delta_y_reg});
    assign diff_y_cmp = err2 - $signed({3'b000, delta_x_reg});
    assign move_x     = !sum_x[WB-1] && (sum_x != '0);
    assign move_y     = diff_y_cmp[WB-1];
    assign step_x     = dir_x_neg_reg ? '1 : CB'(1);
    assign step_y     = dir_y_neg_reg ? '1 : CB'(1);
    assign err_sub    = move_x ? $signed({2'b00, delta_y_reg}) : '0;
    assign err_add    = move_y ? $signed({2'b00, delta_x_reg}) : '0;
    assign nx         = move_x ? (cur_x_reg + step_x) : cur_x_reg;
    assign ny         = move_y ? (cur_y_reg + step_y) : cur_y_reg;
    assign step_last  = (nx == target_x_reg) && (ny == target_y_reg);

    // dash pattern
    logic [DASH_BITS-1:0]   dash_cur;
    logic                   dash_vis;
    logic [DASH_BITS-1:0]   dash_wrap;

    assign dash_cur = (op_reg == OP_START) ? '0 : dash_count_reg;

    bdls_dash u_dash (
        .cfg        (dash_cfg_reg),
        .count      (dash_cur),
        .visible    (dash_vis),
        .count_next (dash_wrap)
    );

    // result fields
    logic signed [CB-1:0]   res_x, res_y;
    logic                   res_vis, res_last, res_none;

    // next state and result for the word in the input register
    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        error_next       = error_reg;
        dir_x_neg_next   = dir_x_neg_reg;
        dir_y_neg_next   = dir_y_neg_reg;
        dash_count_next  = dash_count_reg;
        line_active_next = line_active_reg;
        res_x            = '0;
        res_y            = '0;
        res_vis          = 1'b0;
        res_last         = 1'b0;
        res_none         = 1'b0;
        if (op_reg == OP_START)
        begin
            cur_x_next       = sx_reg;
            cur_y_next       = sy_reg;
            target_x_next    = ex_reg;
            target_y_next    = ey_reg;
            delta_x_next     = abs_x[CB-1:0];
            delta_y_next     = abs_y[CB-1:0];
            dir_x_neg_next   = diff_x[CB] || (diff_x == '0);
            dir_y_neg_next   = diff_y[CB] || (diff_y == '0);
            error_next       = $signed({2'b00, abs_x[CB-1:0]}) - $signed({2'b00, abs_y[CB-1:0]});
            dash_count_next  = dash_wrap;
            line_active_next = !start_last;
            res_x            = sx_reg;
            res_y            = sy_reg;
            res_vis          = dash_vis;
            res_last         = start_last;
        end
        else if (!line_active_reg)
        begin
            res_none = 1'b1;
        end
        else
        begin
            cur_x_next       = nx;
            cur_y_next       = ny;
            error_next       = error_reg - err_sub + err_add;
            dash_count_next  = dash_wrap;
            line_active_next = !step_last;
            res_x            = nx;
            res_y            = ny;
            res_vis          = dash_vis;
            res_last         = step_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            error_reg       <= '0;
            dir_x_neg_reg   <= 1'b0;
            dir_y_neg_reg   <= 1'b0;
            dash_count_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (advance)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            error_reg       <= error_next;
            dir_x_neg_reg   <= dir_x_neg_next;
            dir_y_neg_reg   <= dir_y_neg_next;
            dash_count_reg  <= dash_count_next;
            line_active_reg <= line_active_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic signed [CB-1:0]   px_reg, py_reg;
    logic                   vis_reg, last_reg, none_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg   <= res_x;
            py_reg   <= res_y;
            vis_reg  <= res_vis;
            last_reg <= res_last;
            none_reg <= res_none;
        end
    end

    assign out_valid     = out_vld_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_visible = vis_reg;
    assign last_pixel    = last_reg;
    assign no_line       = none_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an active line never sits on its end point
    a_active_not_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> ((cur_x_reg != target_x_reg) || (cur_y_reg != target_y_reg)))
        else $error("active line parked on its end point");

    // emitting the end point retires the line
    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_last) |=> !line_active_reg)
        else $error("line still active after last pixel");

    // a no-line result carries zero pixel fields
    a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && none_reg) |->
            ((px_reg == '0) && (py_reg == '0) && !vis_reg && !last_reg))
        else $error("no-line result with nonzero fields");

    // a step with no line leaves the dash counter untouched
    a_no_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_none) |=> $stable(dash_count_reg))
        else $error("dash counter moved on a no-line step");

endmodule

@@ tb/bresenham_dashed_line_stepper_unit_test.sv @@
// Self-checking testbench for bresenham_dashed_line_stepper_unit: directed table plus
// random line traffic under several dash settings, checked against a local line tracer.
// Depends on bdls_pkg and the RTL of the stepper unit.
module bresenham_dashed_line_stepper_unit_test;
    import bdls_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int WORDS_PER_PHASE = 140;
    localparam int LINE_PHASES     = 10;
    localparam int STALL_LIMIT     = 2000;
    localparam int COORD_MAX       = 2047;
    localparam int COORD_MIN       = -2048;
    // address past the last register: writes must be ignored
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        op_t    kind;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } line_word_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        logic   vis;
        logic   is_last;
        logic   no_ln;
    } pixel_word_t;

    // DUT connections
    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     op;
    coord_t                   start_x;
    coord_t                   start_y;
    coord_t                   end_x;
    coord_t                   end_y;
    logic                     out_valid;
    logic                     out_stall;
    coord_t                   pixel_x;
    coord_t                   pixel_y;
    logic                     pixel_visible;
    logic                     last_pixel;
    logic                     no_line;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [REG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // line tracer state and its copy of the registers
    int          pen_x = 0;
    int          pen_y = 0;
    int          goal_x = 0;
    int          goal_y = 0;
    int          span_x = 0;
    int          span_y = 0;
    int          err_acc = 0;
    bit          x_back = 0;
    bit          y_back = 0;
    int unsigned dash_pos = 0;
    bit          drawing = 0;
    bit          dash_en_q = 0;
    int unsigned dash_per_q = DASH_PERIOD_RST;
    int unsigned dash_on_q = DASH_ON_RST;

    // pixels still owed by the DUT, oldest first
    pixel_word_t pixel_backlog[$];

    // word currently offered on the input channel
    line_word_t  tx_word;
    bit          tx_has;
    pixel_word_t tx_pix;

    int err_count = 0;
    int tx_quiet = 0;
    int rx_quiet = 0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    // directed table
    line_word_t  dir_words[$];
    bit          dir_has[$];
    pixel_word_t dir_pix[$];

    bresenham_dashed_line_stepper_unit #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_visible(pixel_visible),
        .last_pixel   (last_pixel),
        .no_line      (no_line),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // emit the current pixel and advance the dash counter
    function automatic pixel_word_t plot_pixel(bit is_last);
        pixel_word_t p;
        p.px      = pen_x[COORD_BITS-1:0];
        p.py      = pen_y[COORD_BITS-1:0];
        p.vis     = !dash_en_q || (dash_pos < dash_on_q);
        p.is_last = is_last;
        p.no_ln   = 1'b0;
        if (dash_pos + 1 >= dash_per_q)
            dash_pos = 0;
        else
            dash_pos = dash_pos + 1;
        return p;
    endfunction

    // line tracer: one word in, one pixel out
    function automatic pixel_word_t rasterize_word(line_word_t w);
        pixel_word_t p;
        int          e2;
        int          sx;
        int          sy;
        int          ex;
        int          ey;
        bit          is_last;
        p = '0;
        if (w.kind == OP_START)
        begin
            sx = w.sx;
            sy = w.sy;
            ex = w.ex;
            ey = w.ey;
            pen_x = sx;
            pen_y = sy;
            goal_x = ex;
            goal_y = ey;
            span_x = (ex > sx) ? ex - sx : sx - ex;
            span_y = (ey > sy) ? ey - sy : sy - ey;
            x_back = !(sx < ex);
            y_back = !(sy < ey);
            err_acc = span_x - span_y;
            dash_pos = 0;
            is_last = (sx == ex) && (sy == ey);
            drawing = !is_last;
            return plot_pixel(is_last);
        end
        // step with nothing to draw
        if (!drawing)
        begin
            p.no_ln = 1'b1;
            return p;
        end
        e2 = 2 * err_acc;
        if (e2 > -span_y)
        begin
            err_acc -= span_y;
            pen_x += x_back ? -1 : 1;
        end
        if (e2 < span_x)
        begin
            err_acc += span_x;
            pen_y += y_back ? -1 : 1;
        end
        is_last = (pen_x == goal_x) && (pen_y == goal_y);
        if (is_last)
            drawing = 0;
        return plot_pixel(is_last);
    endfunction

    // input acceptance feeds the tracer, output acceptance is checked
    always @(posedge clk)
    begin : word_monitor
        pixel_word_t pred;
        pixel_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pred = rasterize_word(tx_word);
                if (tx_has)
                    pred = tx_pix;
                pixel_backlog.push_back(pred);
            end
            if (out_valid && !out_stall)
            begin
                if (pixel_backlog.size() == 0)
                    flag_error("pixel word with none pending");
                else
                begin
                    want = pixel_backlog.pop_front();
                    check_field("pixel_x", pixel_x, want.px);
                    check_field("pixel_y", pixel_y, want.py);
                    check_field("pixel_visible", pixel_visible, want.vis);
                    check_field("last_pixel", last_pixel, want.is_last);
                    check_field("no_line", no_line, want.no_ln);
                end
                // draw the next receiver stall, with calm stretches now and then
                if (rx_quiet > 0)
                begin
                    rx_quiet--;
                    rx_hold = 0;
                end
                else
                begin
                    rx_hold = $urandom_range(0, 6);
                    if ($urandom_range(0, 19) == 0)
                        rx_quiet = $urandom_range(10, 40);
                end
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL bresenham_dashed_line_stepper_unit");
                $finish;
            end
        end
    end

    // one word on the input channel, after a random gap; returns at the next falling edge
    task automatic drive_word(line_word_t w, bit has, pixel_word_t pix);
        int gap;
        if (tx_quiet > 0)
        begin
            tx_quiet--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                tx_quiet = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tx_word = w;
        tx_has = has;
        tx_pix = pix;
        in_valid <= 1'b1;
        op <= w.kind;
        start_x <= w.sx;
        start_y <= w.sy;
        end_x <= w.ex;
        end_y <= w.ey;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // APB transfer, starting and ending at a falling edge; psel stays up for back-to-back
    task automatic cfg_access(logic [REG_IDX_BITS-1:0] idx, bit wr, logic [31:0] data,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [REG_IDX_BITS-1:0] idx, logic [31:0] data);
        logic [31:0] rd;
        cfg_access(idx, 1'b1, data, rd);
        case (idx)
            REG_DASH_ENABLE: dash_en_q = data[0];
            REG_DASH_PERIOD: dash_per_q = data[DASH_BITS-1:0];
            REG_DASH_ON:     dash_on_q = data[DASH_BITS-1:0];
            default:         ;
        endcase
    endtask

    task automatic cfg_verify(logic [REG_IDX_BITS-1:0] idx, logic [3:0] want,
                              logic [3:0] mask);
        logic [31:0] rd;
        cfg_access(idx, 1'b0, '0, rd);
        if ((rd[3:0] & mask) !== (want & mask))
            flag_error($sformatf("register %0d reads %0h want %0h", idx, rd, want));
    endtask

    task automatic verify_regs();
        cfg_verify(REG_DASH_ENABLE, {3'b000, dash_en_q}, 4'h1);
        cfg_verify(REG_DASH_PERIOD, dash_per_q[3:0], 4'hf);
        cfg_verify(REG_DASH_ON, dash_on_q[3:0], 4'hf);
    endtask

    // program the dash pattern with junk in the unused upper bits, write the spare register, read all back
    task automatic set_dash(bit en, int per, int on_len);
        logic [31:0] d;
        d = $urandom;
        d[0] = en;
        cfg_write(REG_DASH_ENABLE, d);
        d = $urandom;
        d[3:0] = per[3:0];
        cfg_write(REG_DASH_PERIOD, d);
        d = $urandom;
        d[3:0] = on_len[3:0];
        cfg_write(REG_DASH_ON, d);
        cfg_write(REG_SPARE, $urandom);
        verify_regs();
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic line_word_t random_word();
        line_word_t w;
        w.kind = OP_STEP;
        w.sx = coord_t'($urandom_range(0, 4095));
        w.sy = coord_t'($urandom_range(0, 4095));
        w.ex = coord_t'($urandom_range(0, 4095));
        w.ey = coord_t'($urandom_range(0, 4095));
        return w;
    endfunction

    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (pixel_backlog.size() != 0) @(negedge clk);
    endtask

    // mostly complete short lines, some cut short or overrun, plus random noise
    task automatic run_line_traffic(int count);
        int          sent;
        int          n;
        int          r;
        int          dx;
        int          dy;
        int          sx;
        int          sy;
        int          ex;
        int          ey;
        int          len;
        line_word_t  w;
        pixel_word_t nil;
        nil = '0;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                w = random_word();
                w.kind = op_t'($urandom_range(0, 1));
                drive_word(w, 1'b0, nil);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? 60 : 10;
                w = random_word();
                w.kind = OP_START;
                sx = w.sx;
                sy = w.sy;
                dx = $urandom_range(0, len);
                dy = $urandom_range(0, len);
                n = (dx > dy) ? dx : dy;
                if ($urandom_range(0, 1))
                    dx = -dx;
                if ($urandom_range(0, 1))
                    dy = -dy;
                ex = sx + dx;
                if (ex > COORD_MAX || ex < COORD_MIN)
                    ex = sx - dx;
                ey = sy + dy;
                if (ey > COORD_MAX || ey < COORD_MIN)
                    ey = sy - dy;
                w.ex = ex[COORD_BITS-1:0];
                w.ey = ey[COORD_BITS-1:0];
                drive_word(w, 1'b0, nil);
                sent++;
                r = $urandom_range(0, 99);
                if (r < 15)
                    n = (n > 0) ? $urandom_range(0, n - 1) : 0;
                else if (r < 25)
                    n += $urandom_range(1, 3);
                repeat (n)
                begin
                    w = random_word();
                    drive_word(w, 1'b0, nil);
                    sent++;
                end
            end
        end
        drain_pixels();
    endtask

    task automatic dir_row(op_t k, int sx, int sy, int ex, int ey, bit has,
                           int px, int py, bit v, bit l, bit n);
        line_word_t  w;
        pixel_word_t p;
        w.kind = k;
        w.sx = sx[COORD_BITS-1:0];
        w.sy = sy[COORD_BITS-1:0];
        w.ex = ex[COORD_BITS-1:0];
        w.ey = ey[COORD_BITS-1:0];
        p.px = px[COORD_BITS-1:0];
        p.py = py[COORD_BITS-1:0];
        p.vis = v;
        p.is_last = l;
        p.no_ln = n;
        dir_words.push_back(w);
        dir_has.push_back(has);
        dir_pix.push_back(p);
    endtask

    // main sequence
    initial
    begin : stimulus
        int dash_en_tab[7];
        int dash_per_tab[7];
        int dash_on_tab[7];
        dash_en_tab  = '{1, 1, 1, 1, 1, 0, 1};
        dash_per_tab = '{10, 0, 1, 15, 4, 7, 15};
        dash_on_tab  = '{5, 3, 0, 15, 9, 2, 0};

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_START;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // directed rows: typed expectations only where obvious
        dir_row(OP_STEP, 1365, -1366, 682, -683, 1, 0, 0, 0, 0, 1);
        dir_row(OP_START, -2048, -2048, 2047, 2047, 1, -2048, -2048, 1, 0, 0);
        dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_row(OP_STEP, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0);
        // start equals end
        dir_row(OP_START, 2047, 2047, 2047, 2047, 1, 2047, 2047, 1, 1, 0);
        dir_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        dir_row(OP_START, 2047, -2048, -2048, 2047, 1, 2047, -2048, 1, 0, 0);
        dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // shallow line, abandoning the previous one
        dir_row(OP_START, 0, 0, 5, 2, 1, 0, 0, 1, 0, 0);
        repeat (5) dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // steep line toward negative x and y
        dir_row(OP_START, 0, 0, -2, -5, 1, 0, 0, 1, 0, 0);
        repeat (5) dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_row(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        dir_row(OP_START, -1, 1, 1, -1, 1, -1, 1, 1, 0, 0);
        repeat (2) dir_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults after reset
        verify_regs();
        psel <= 1'b0;
        penable <= 1'b0;

        for (int i = 0; i < dir_words.size(); i++)
            drive_word(dir_words[i], dir_has[i], dir_pix[i]);
        drain_pixels();

        for (int ph = 0; ph < LINE_PHASES; ph++)
        begin
            if (ph < 7)
                set_dash(dash_en_tab[ph][0], dash_per_tab[ph], dash_on_tab[ph]);
            else
                set_dash(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            run_line_traffic(WORDS_PER_PHASE);
        end

        while (pixel_backlog.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("PASS bresenham_dashed_line_stepper_unit");
        else
            $display("FAIL bresenham_dashed_line_stepper_unit");
        $finish;
    end

endmodule

@@ bresenham_dashed_line_stepper_unit.f @@
rtl/core/bdls_pkg.sv
rtl/core/bdls_dash.sv
rtl/core/bresenham_dashed_line_stepper_unit.sv
tb/bresenham_dashed_line_stepper_unit_test.sv
